// ===== sv/ntks_pkg.sv =====
// Package for the neighbour table: sizes, codes, controller states and the
// command and status bundles between controller and datapath.
// No dependencies.
package ntks_pkg;

  // Table geometry
  localparam int TABLE_SLOTS = 20;
  localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

  // Field widths
  localparam int SLOT_W = 5;
  localparam int MAC_W  = 48;
  localparam int LVL_W  = 8;
  localparam int QUAL_W = 8;
  localparam int REC_W  = MAC_W + LVL_W + QUAL_W;

  // Request action codes
  typedef enum logic [1:0] {
    ACT_REPORT = 2'd0,
    ACT_READ   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Result outcome codes
  typedef enum logic [2:0] {
    OUT_REFRESHED = 3'd0,
    OUT_KEPT      = 3'd1,
    OUT_INSERTED  = 3'd2,
    OUT_REPLACED  = 3'd3,
    OUT_DROPPED   = 3'd4,
    OUT_SKIPPED   = 3'd5,
    OUT_READ      = 3'd6,
    OUT_CLEARED   = 3'd7
  } outcome_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_WEAK,
    ST_FETCH,
    ST_OUT
  } state_t;

  // How the datapath forms the result on commit
  typedef enum logic [1:0] {
    FIN_PLAIN,
    FIN_READ,
    FIN_HIT,
    FIN_WEAK
  } fin_t;

  typedef struct packed {
    logic load;      // latch the incoming request
    logic rd_scan;   // read the next slot of the scan
    logic rd_sel;    // read the selected slot
    logic cmp;       // compare the slot just read
    logic commit;    // write back and form the result
    fin_t fin;
    logic load_out;  // move the result into the output register
  } ntks_cmd_t;

  typedef struct packed {
    action_t act;
    logic    self_mac;  // request MAC equals the anchor
    logic    hit;       // slot read matches or is empty
    logic    last;      // slot read is the final slot
    logic    sel_ok;    // selected slot lies inside the table
    logic    out_free;  // output register can take a result
  } ntks_stat_t;

endpackage

// ===== sv/ntks_ctrl.sv =====
// Controller for the neighbour table: sequences decode, slot scan, write-back
// and output hand-off. Depends on ntks_pkg.
module ntks_ctrl import ntks_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  ntks_stat_t stat,
  output ntks_cmd_t  cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (stat.act)
          ACT_READ:   state_next = ST_FETCH;
          ACT_REPORT: state_next = stat.self_mac ? ST_OUT : ST_SCAN;
          default:    state_next = ST_OUT;
        endcase
      end
      ST_SCAN: begin
        if (stat.hit) begin
          state_next = ST_OUT;
        end else if (stat.last) begin
          state_next = ST_WEAK;
        end
      end
      ST_WEAK:  state_next = ST_OUT;
      ST_FETCH: state_next = ST_OUT;
      ST_OUT: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    cmd.fin  = FIN_PLAIN;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: cmd.load = in_valid;
      ST_DECODE: begin
        if (stat.act == ACT_READ) begin
          cmd.rd_sel = stat.sel_ok;
        end else if (stat.act == ACT_REPORT && !stat.self_mac) begin
          cmd.rd_scan = 1'b1;
        end else begin
          cmd.commit = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd.cmp     = 1'b1;
        cmd.rd_scan = 1'b1;
        cmd.commit  = stat.hit;
        cmd.fin     = FIN_HIT;
      end
      ST_WEAK: begin
        cmd.commit = 1'b1;
        cmd.fin    = FIN_WEAK;
      end
      ST_FETCH: begin
        cmd.commit = 1'b1;
        cmd.fin    = FIN_READ;
      end
      ST_OUT:  cmd.load_out = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/ntks_dpath.sv =====
// Datapath for the neighbour table: request and anchor registers, slot memory
// with valid bits, scan compare, weakest tracking and result registers.
// Depends on ntks_pkg.
module ntks_dpath import ntks_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  ntks_cmd_t                cmd,
  output ntks_stat_t               stat,
  input  logic                     anchor_mac_we,
  input  logic        [MAC_W-1:0]  anchor_mac,
  input  logic        [1:0]        action,
  input  logic        [MAC_W-1:0]  neighbour_mac,
  input  logic signed [LVL_W-1:0]  signal_level,
  input  logic        [QUAL_W-1:0] link_quality,
  input  logic        [SLOT_W-1:0] slot_select,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic        [2:0]        outcome,
  output logic        [SLOT_W-1:0] slot_index,
  output logic        [MAC_W-1:0]  slot_mac,
  output logic signed [LVL_W-1:0]  slot_level,
  output logic        [QUAL_W-1:0] slot_quality
);

  logic        [MAC_W-1:0]  anchor;
  action_t                  req_act;
  logic        [MAC_W-1:0]  req_mac;
  logic signed [LVL_W-1:0]  req_lvl;
  logic        [QUAL_W-1:0] req_q;
  logic        [SLOT_W-1:0] req_sel;
  logic        [REC_W-1:0]  req_rec;

  logic [REC_W-1:0]       mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] vld;
  logic [REC_W-1:0]       mem_q;
  logic                   rd_vld;
  logic [IDX_W-1:0]       rd_idx;
  logic [IDX_W-1:0]       rd_addr;
  logic                   rd_en;
  logic [CNT_W-1:0]       scan_cnt;
  logic                   scan_more;

  logic [REC_W-1:0]       cur;
  logic [MAC_W-1:0]       cur_mac;
  logic signed [LVL_W-1:0] cur_lvl;
  logic                   match;
  logic                   empty;

  logic signed [LVL_W-1:0] min_level;
  logic [IDX_W-1:0]        min_idx;

  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic                   clear_all;
  outcome_t               res_outcome_next;
  logic [SLOT_W-1:0]      res_idx_next;
  logic [REC_W-1:0]       res_rec_next;
  outcome_t               res_outcome;
  logic [SLOT_W-1:0]      res_idx;
  logic [REC_W-1:0]       res_rec;

  // Anchor register
  always_ff @(posedge clk) begin
    if (rst) begin
      anchor <= '0;
    end else if (anchor_mac_we) begin
      anchor <= anchor_mac;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_act <= action_t'(action);
      req_mac <= neighbour_mac;
      req_lvl <= signal_level;
      req_q   <= link_quality;
      req_sel <= slot_select;
    end
  end

  assign req_rec = {req_q, req_lvl, req_mac};

  // Scan counter and read address
  assign scan_more = (scan_cnt < CNT_W'(TABLE_SLOTS));
  assign rd_en     = (cmd.rd_scan && scan_more) || cmd.rd_sel;
  assign rd_addr   = cmd.rd_sel ? req_sel[IDX_W-1:0] : scan_cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_cnt <= '0;
    end else if (cmd.rd_scan && scan_more) begin
      scan_cnt <= scan_cnt + CNT_W'(1);
    end
  end

  // Slot memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= req_rec;
    end
    if (rd_en) begin
      mem_q  <= mem[rd_addr];
      rd_vld <= vld[rd_addr];
      rd_idx <= rd_addr;
    end
  end

  // Valid bits: an invalid slot reads as empty
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Slot compare
  assign cur     = rd_vld ? mem_q : '0;
  assign cur_mac = cur[MAC_W-1:0];
  assign cur_lvl = cur[MAC_W+LVL_W-1:MAC_W];
  assign match   = (cur_mac == req_mac);
  assign empty   = (cur == '0);

  // Weakest slot below zero
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      min_level <= '0;
      min_idx   <= '0;
    end else if (cmd.cmp && !(match || empty) && (cur_lvl < min_level)) begin
      min_level <= cur_lvl;
      min_idx   <= rd_idx;
    end
  end

  // Status
  always_comb begin
    stat          = '0;
    stat.act      = req_act;
    stat.self_mac = (req_mac == anchor);
    stat.hit      = match || empty;
    stat.last     = (rd_idx == IDX_W'(TABLE_SLOTS - 1));
    stat.sel_ok   = (req_sel < SLOT_W'(TABLE_SLOTS));
    stat.out_free = !out_valid || !out_stall;
  end

  // Write-back and result forming
  always_comb begin
    wr_en            = 1'b0;
    wr_addr          = rd_idx;
    clear_all        = 1'b0;
    res_outcome_next = OUT_DROPPED;
    res_idx_next     = '0;
    res_rec_next     = '0;
    unique case (cmd.fin)
      FIN_PLAIN: begin
        if (req_act == ACT_CLEAR) begin
          res_outcome_next = OUT_CLEARED;
          clear_all        = cmd.commit;
        end else if (req_act == ACT_REPORT) begin
          res_outcome_next = OUT_SKIPPED;
        end
      end
      FIN_READ: begin
        res_outcome_next = OUT_READ;
        res_idx_next     = req_sel;
        res_rec_next     = stat.sel_ok ? cur : '0;
      end
      FIN_HIT: begin
        res_idx_next = SLOT_W'(rd_idx);
        if (match) begin
          if (req_lvl > cur_lvl) begin
            wr_en            = cmd.commit;
            res_outcome_next = OUT_REFRESHED;
            res_rec_next     = req_rec;
          end else begin
            res_outcome_next = OUT_KEPT;
            res_rec_next     = cur;
          end
        end else begin
          wr_en            = cmd.commit;
          res_outcome_next = OUT_INSERTED;
          res_rec_next     = req_rec;
        end
      end
      FIN_WEAK: begin
        if (min_level < req_lvl) begin
          wr_en            = cmd.commit;
          wr_addr          = min_idx;
          res_outcome_next = OUT_REPLACED;
          res_idx_next     = SLOT_W'(min_idx);
          res_rec_next     = req_rec;
        end
      end
      default: res_outcome_next = OUT_DROPPED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_outcome <= res_outcome_next;
      res_idx     <= res_idx_next;
      res_rec     <= res_rec_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      outcome      <= res_outcome;
      slot_index   <= res_idx;
      slot_mac     <= res_rec[MAC_W-1:0];
      slot_level   <= res_rec[MAC_W+LVL_W-1:MAC_W];
      slot_quality <= res_rec[REC_W-1:MAC_W+LVL_W];
    end
  end

endmodule

// ===== sv/neighbour_table_keep_strongest_core.sv =====
// Neighbour table keeping the strongest neighbours: top level joining the
// controller and datapath. Depends on ntks_pkg, ntks_ctrl and ntks_dpath.
//
// Holds 20 neighbour records and takes one request at a time. A report walks
// the slot memory one slot per cycle through its single read port; when the
// whole table is walked with no match and no empty slot, the weak state settles
// the weakest slot. A read fetches the selected slot; clear, an unused action
// and a report of the anchor MAC commit straight from decode. The
// result sits in an output register until taken; the next request is accepted
// once that register has received the result. Clear acts at once on the valid
// bits, and a slot never written reads as empty. The anchor MAC may be
// written whenever the block is idle.
module neighbour_table_keep_strongest_core import ntks_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     anchor_mac_we,
  input  logic        [MAC_W-1:0]  anchor_mac,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic        [1:0]        action,
  input  logic        [MAC_W-1:0]  neighbour_mac,
  input  logic signed [LVL_W-1:0]  signal_level,
  input  logic        [QUAL_W-1:0] link_quality,
  input  logic        [SLOT_W-1:0] slot_select,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic        [2:0]        outcome,
  output logic        [SLOT_W-1:0] slot_index,
  output logic        [MAC_W-1:0]  slot_mac,
  output logic signed [LVL_W-1:0]  slot_level,
  output logic        [QUAL_W-1:0] slot_quality
);

  ntks_cmd_t  cmd;
  ntks_stat_t stat;

  ntks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ntks_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .anchor_mac_we (anchor_mac_we),
    .anchor_mac    (anchor_mac),
    .action        (action),
    .neighbour_mac (neighbour_mac),
    .signal_level  (signal_level),
    .link_quality  (link_quality),
    .slot_select   (slot_select),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .outcome       (outcome),
    .slot_index    (slot_index),
    .slot_mac      (slot_mac),
    .slot_level    (slot_level),
    .slot_quality  (slot_quality)
  );

  // An accepted request keeps the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted but block not busy");

  // A new result only appears while a request is in progress
  a_result_has_request: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in progress");

  // A written or matched slot lies inside the table
  a_slot_in_table: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (outcome == OUT_REFRESHED || outcome == OUT_KEPT ||
                   outcome == OUT_INSERTED || outcome == OUT_REPLACED))
    |-> (slot_index < SLOT_W'(TABLE_SLOTS)))
    else $error("slot index outside table");

  // Results that touch no slot carry zero fields
  a_no_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (outcome == OUT_DROPPED || outcome == OUT_SKIPPED ||
                   outcome == OUT_CLEARED))
    |-> (slot_index == '0 && slot_mac == '0 && slot_level == '0 &&
         slot_quality == '0))
    else $error("non-zero slot fields on a result without a slot");

endmodule
